### hw/rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and character codes for the CAN frame text parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_X_UC  = 8'h58;  // 'X'
    localparam logic [7:0] CH_X_LC  = 8'h78;  // 'x'
    localparam logic [7:0] CH_N_UC  = 8'h4E;  // 'N'
    localparam logic [7:0] CH_N_LC  = 8'h6E;  // 'n'
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UC  = 8'h41;
    localparam logic [7:0] CH_F_UC  = 8'h46;
    localparam logic [7:0] CH_A_LC  = 8'h61;
    localparam logic [7:0] CH_F_LC  = 8'h66;

    localparam int unsigned ID_W      = 29;
    localparam int unsigned ACC_W     = 32;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned SLOTS     = 8;
    localparam int unsigned PAY_W     = 64;
    localparam int unsigned OUT_DATA_W = 104;  // 97 field bits padded to bytes

    // decoded character, registered at the input
    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_colon;
        logic       is_x;
        logic       is_n;
        logic       is_semi;
    } t_char_class;

    // result of one step of the frame tracker
    typedef struct packed {
        logic             fire;
        logic [ID_W-1:0]  can_id;
        logic [CNT_W-1:0] byte_count;
        logic [PAY_W-1:0] payload;
    } t_frame_result;

endpackage

### hw/rtl/cfp_char_decode.sv
// ----------------------------------------------------------------------------
// cfp_char_decode
// Classifies one ASCII character: hex digit value and frame delimiters.
// ----------------------------------------------------------------------------
module cfp_char_decode (
    input  logic [7:0]           i_char,
    output cfp_pkg::t_char_class o_class
);

    always_comb begin
        o_class          = '0;
        o_class.is_colon = (i_char == cfp_pkg::CH_COLON);
        o_class.is_semi  = (i_char == cfp_pkg::CH_SEMI);
        o_class.is_x     = (i_char == cfp_pkg::CH_X_UC) || (i_char == cfp_pkg::CH_X_LC);
        o_class.is_n     = (i_char == cfp_pkg::CH_N_UC) || (i_char == cfp_pkg::CH_N_LC);
        if (i_char >= cfp_pkg::CH_0 && i_char <= cfp_pkg::CH_9) begin
            o_class.is_hex = 1'b1;
            o_class.nibble = i_char[3:0];
        end else if (i_char >= cfp_pkg::CH_A_UC && i_char <= cfp_pkg::CH_F_UC) begin
            o_class.is_hex = 1'b1;
            o_class.nibble = 4'(i_char - cfp_pkg::CH_A_UC + 8'd10);
        end else if (i_char >= cfp_pkg::CH_A_LC && i_char <= cfp_pkg::CH_F_LC) begin
            o_class.is_hex = 1'b1;
            o_class.nibble = 4'(i_char - cfp_pkg::CH_A_LC + 8'd10);
        end
    end

endmodule

### hw/rtl/cfp_frame_fsm.sv
// ----------------------------------------------------------------------------
// cfp_frame_fsm
// Frame tracker: phase, identifier accumulator and data byte slots.
// ----------------------------------------------------------------------------
module cfp_frame_fsm #(
    parameter int unsigned MAX_BYTES = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  cfp_pkg::t_char_class   i_class,
    output cfp_pkg::t_frame_result o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TYPE,
        PH_ID,
        PH_DATA
    } t_phase;

    localparam logic [cfp_pkg::CNT_W-1:0] MAX_CNT = cfp_pkg::CNT_W'(MAX_BYTES);

    t_phase                       r_phase;
    logic [cfp_pkg::ACC_W-1:0]    r_id_accum;
    logic [cfp_pkg::CNT_W-1:0]    r_bytes_done;
    logic                         r_low_next;
    logic [7:0]                   r_data [cfp_pkg::SLOTS];

    logic [2:0] w_slot;
    assign w_slot = r_bytes_done[2:0];

    // result is formed from the state as it stands before this item
    always_comb begin
        o_result            = '0;
        o_result.fire       = i_step && (r_phase == PH_DATA) && i_class.is_semi;
        o_result.can_id     = r_id_accum[cfp_pkg::ID_W-1:0];
        o_result.byte_count = r_bytes_done;
        for (int i = 0; i < cfp_pkg::SLOTS; i++) begin
            if (r_bytes_done > cfp_pkg::CNT_W'(i)) begin
                o_result.payload[8*i +: 8] = r_data[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_id_accum   <= '0;
            r_bytes_done <= '0;
            r_low_next   <= 1'b0;
        end else if (i_step) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_class.is_colon) begin
                        r_id_accum   <= '0;
                        r_bytes_done <= '0;
                        r_low_next   <= 1'b0;
                        r_phase      <= PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    r_phase <= i_class.is_x ? PH_ID : PH_IDLE;
                end
                PH_ID: begin
                    if (i_class.is_n) begin
                        r_phase <= PH_DATA;
                    end else if (i_class.is_hex) begin
                        r_id_accum <= {r_id_accum[cfp_pkg::ACC_W-5:0], i_class.nibble};
                    end else begin
                        r_phase <= PH_IDLE;
                    end
                end
                PH_DATA: begin
                    if (i_class.is_semi || !i_class.is_hex) begin
                        r_phase <= PH_IDLE;
                    end else if (r_bytes_done < MAX_CNT) begin
                        // extra digits past the last slot are dropped
                        if (!r_low_next) begin
                            r_data[w_slot] <= {i_class.nibble, 4'h0};
                            r_low_next     <= 1'b1;
                        end else begin
                            r_data[w_slot] <= {r_data[w_slot][7:4], i_class.nibble};
                            r_bytes_done   <= r_bytes_done + 1'b1;
                            r_low_next     <= 1'b0;
                        end
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/can_frame_ascii_parser_core.sv
// ----------------------------------------------------------------------------
// can_frame_ascii_parser_core
// Parses ':X<id>N<data>;' extended CAN frames from an ASCII byte stream.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] = char_in
//  m_axis    out  tdata[28:0] = can_id, [32:29] = byte_count, [96:33] = payload
//
//  one character per cycle sustained unless a result waits on m_axis; after ';'
//  the frame result passes the decoded input register, then the result register
//  the result register stalls the tracker only while a result waits on m_axis
//  synchronous active-low reset returns the tracker to idle, no output pending
// ----------------------------------------------------------------------------
module can_frame_ascii_parser_core #(
    parameter int unsigned MAX_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] char_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [28:0] can_id, [32:29] byte_count, [96:33] payload, [103:97] zero
    output logic [cfp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    cfp_pkg::t_char_class   w_class;
    cfp_pkg::t_char_class   r_class;
    logic                   r_in_vld;
    cfp_pkg::t_frame_result w_result;
    logic                   r_out_vld;
    logic [cfp_pkg::ID_W-1:0]  r_out_id;
    logic [cfp_pkg::CNT_W-1:0] r_out_count;
    logic [cfp_pkg::PAY_W-1:0] r_out_pay;
    logic                   w_go;
    logic                   w_step;

    // tracker may advance when the result register is free or draining
    assign w_go          = !r_out_vld || m_axis_tready;
    assign w_step        = r_in_vld && w_go;
    assign s_axis_tready = !r_in_vld || w_go;

    cfp_char_decode u_decode (
        .i_char  (s_axis_tdata),
        .o_class (w_class)
    );

    cfp_frame_fsm #(
        .MAX_BYTES (MAX_BYTES)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_class  (r_class),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_class <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_go) begin
            r_out_vld <= w_result.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_result.fire) begin
            r_out_id    <= w_result.can_id;
            r_out_count <= w_result.byte_count;
            r_out_pay   <= w_result.payload;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out_pay, r_out_count, r_out_id};

    // a result only appears after a registered character was processed
    a_out_from_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_in_vld))
        else $error("result appeared without a processed character");

    // byte count never exceeds the configured slot limit
    a_count_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_count <= cfp_pkg::CNT_W'(MAX_BYTES)))
        else $error("byte count above limit");

    // a blocked character stays in the input register
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_go) |=> (r_in_vld && $stable(r_class)))
        else $error("stalled character lost");

endmodule
